[rtl/cpwm_pkg.sv]
// ----------------------------------------------------------------------------
// Capture period window monitor package
// Shared types, register indexes, reset values and helpers.
// ----------------------------------------------------------------------------
package cpwm_pkg;

  localparam int unsigned CntW        = 16;
  localparam int unsigned StampInW    = 16;
  localparam int unsigned StampWidth  = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD_LOW       = 3'd0,
    CFG_PERIOD_HIGH      = 3'd1,
    CFG_WINDOW_TICKS     = 3'd2,
    CFG_MIN_CAPTURES     = 3'd3,
    CFG_MIN_GOOD_PERIODS = 3'd4,
    CFG_STATUS_TICKS     = 3'd5,
    CFG_BLINK_GOOD_TICKS = 3'd6,
    CFG_BLINK_BAD_TICKS  = 3'd7
  } cfg_idx_e;

  localparam logic [CfgDataW-1:0] RstPeriodLow      = 16'd150;
  localparam logic [CfgDataW-1:0] RstPeriodHigh     = 16'd250;
  localparam logic [CfgDataW-1:0] RstWindowTicks    = 16'd100;
  localparam logic [CfgDataW-1:0] RstMinCaptures    = 16'd3;
  localparam logic [CfgDataW-1:0] RstMinGoodPeriods = 16'd2;
  localparam logic [CfgDataW-1:0] RstStatusTicks    = 16'd10;
  localparam logic [CfgDataW-1:0] RstBlinkGoodTicks = 16'd500;
  localparam logic [CfgDataW-1:0] RstBlinkBadTicks  = 16'd250;

  typedef struct packed {
    logic [CfgDataW-1:0] period_low;
    logic [CfgDataW-1:0] period_high;
    logic [CfgDataW-1:0] window_ticks;
    logic [CfgDataW-1:0] min_captures;
    logic [CfgDataW-1:0] min_good_periods;
    logic [CfgDataW-1:0] status_ticks;
    logic [CfgDataW-1:0] blink_good_ticks;
    logic [CfgDataW-1:0] blink_bad_ticks;
  } cfg_t;

  typedef struct packed {
    logic                capture_valid;
    logic [StampInW-1:0] capture_value;
    logic                tick;
  } in_word_t;

  typedef struct packed {
    logic signal_good;
    logic status_pin;
    logic led_pin;
  } out_word_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + {{(CntW-1){1'b0}}, 1'b1};
  endfunction

endpackage

[rtl/cpwm_core.sv]
// ----------------------------------------------------------------------------
// Capture period window monitor core
// Holds the monitor state and works out the next state and result of a word.
// ----------------------------------------------------------------------------
module cpwm_core #(
  parameter int unsigned STAMP_WIDTH = cpwm_pkg::StampWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  cpwm_pkg::cfg_t      cfg_i,
  input  cpwm_pkg::in_word_t  word_i,
  output cpwm_pkg::out_word_t result_o
);
  import cpwm_pkg::*;

  localparam int unsigned CmpW = (STAMP_WIDTH > CfgDataW) ? STAMP_WIDTH : CfgDataW;

  logic                   have_prev_q, have_prev_d;
  logic [STAMP_WIDTH-1:0] prev_cap_q, prev_cap_d;
  logic [CntW-1:0]        cap_total_q, cap_total_d;
  logic [CntW-1:0]        good_total_q, good_total_d;
  logic [CntW-1:0]        win_cnt_q, win_cnt_d;
  logic [CntW-1:0]        stat_cnt_q, stat_cnt_d;
  logic [CntW-1:0]        led_cnt_q, led_cnt_d;
  logic                   phase_q, phase_d;
  logic                   good_q, good_d;
  logic                   stat_lvl_q, stat_lvl_d;
  logic                   led_lvl_q, led_lvl_d;

  logic [STAMP_WIDTH-1:0] stamp;
  logic [STAMP_WIDTH-1:0] diff;
  logic [CmpW-1:0]        diff_ext;
  logic                   in_window;
  logic [CntW-1:0]        cap_total_c, good_total_c;
  logic [CntW-1:0]        win_inc, stat_inc, led_inc;
  logic [CfgDataW-1:0]    led_limit;

  assign stamp     = STAMP_WIDTH'(word_i.capture_value);
  assign diff      = stamp - prev_cap_q;
  assign diff_ext  = CmpW'(diff);
  assign in_window = (diff_ext >= CmpW'(cfg_i.period_low)) &&
                     (diff_ext <= CmpW'(cfg_i.period_high));
  assign win_inc   = sat_inc(win_cnt_q);
  assign stat_inc  = sat_inc(stat_cnt_q);
  assign led_inc   = sat_inc(led_cnt_q);

  always_comb begin
    have_prev_d  = have_prev_q;
    prev_cap_d   = prev_cap_q;
    cap_total_c  = cap_total_q;
    good_total_c = good_total_q;
    if (word_i.capture_valid) begin
      if (have_prev_q && in_window) begin
        good_total_c = sat_inc(good_total_q);
      end
      have_prev_d = 1'b1;
      prev_cap_d  = stamp;
      cap_total_c = sat_inc(cap_total_q);
    end

    cap_total_d  = cap_total_c;
    good_total_d = good_total_c;
    win_cnt_d    = win_cnt_q;
    stat_cnt_d   = stat_cnt_q;
    led_cnt_d    = led_cnt_q;
    good_d       = good_q;
    phase_d      = phase_q;
    stat_lvl_d   = stat_lvl_q;
    led_lvl_d    = led_lvl_q;
    led_limit    = cfg_i.blink_bad_ticks;

    if (word_i.tick) begin
      win_cnt_d  = win_inc;
      stat_cnt_d = stat_inc;
      led_cnt_d  = led_inc;

      if (win_inc >= cfg_i.window_ticks) begin
        good_d       = (cap_total_c >= cfg_i.min_captures) &&
                       (good_total_c >= cfg_i.min_good_periods);
        cap_total_d  = '0;
        good_total_d = '0;
        win_cnt_d    = '0;
      end

      if (stat_inc >= cfg_i.status_ticks) begin
        stat_cnt_d = '0;
        phase_d    = !phase_q;
        stat_lvl_d = good_d && !phase_q;
      end

      led_limit = good_d ? cfg_i.blink_good_ticks : cfg_i.blink_bad_ticks;
      if (led_inc >= led_limit) begin
        led_cnt_d = '0;
        led_lvl_d = !led_lvl_q;
      end
    end
  end

  assign result_o.signal_good = good_d;
  assign result_o.status_pin  = stat_lvl_d;
  assign result_o.led_pin     = led_lvl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      prev_cap_q   <= '0;
      cap_total_q  <= '0;
      good_total_q <= '0;
      win_cnt_q    <= '0;
      stat_cnt_q   <= '0;
      led_cnt_q    <= '0;
      phase_q      <= 1'b0;
      good_q       <= 1'b0;
      stat_lvl_q   <= 1'b0;
      led_lvl_q    <= 1'b1;
    end else if (step_i) begin
      have_prev_q  <= have_prev_d;
      prev_cap_q   <= prev_cap_d;
      cap_total_q  <= cap_total_d;
      good_total_q <= good_total_d;
      win_cnt_q    <= win_cnt_d;
      stat_cnt_q   <= stat_cnt_d;
      led_cnt_q    <= led_cnt_d;
      phase_q      <= phase_d;
      good_q       <= good_d;
      stat_lvl_q   <= stat_lvl_d;
      led_lvl_q    <= led_lvl_d;
    end
  end

endmodule

[rtl/capture_period_window_monitor.sv]
// ----------------------------------------------------------------------------
// Capture period window monitor
// Counts good capture periods per tick window and drives status and LED pins.
// ----------------------------------------------------------------------------
// Each accepted input word may carry a capture timestamp, a millisecond tick,
// or both, and yields exactly one output word with the current judgement, the
// status pin level and the LED level. A word is taken whenever the input is
// ready, up to one word per clock; its state update is one compare-and-count
// step whose result is registered into the output. A two-deep output buffer
// keeps the input ready for one more word while the downstream side stalls.
// The user must write configuration registers through the write port only
// while no word is in flight; the block itself does not enforce this.
module capture_period_window_monitor #(
  parameter int unsigned STAMP_WIDTH = cpwm_pkg::StampWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  cpwm_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cpwm_pkg::out_word_t               out_word_o,
  input  logic                              cfg_we_i,
  input  logic [cpwm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [cpwm_pkg::CfgDataW-1:0]     cfg_data_i
);
  import cpwm_pkg::*;

  cfg_t      cfg_q;
  out_word_t result;
  out_word_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;
  logic      in_fire;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  cpwm_core #(
    .STAMP_WIDTH(STAMP_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_fire),
    .cfg_i   (cfg_q),
    .word_i  (in_word_i),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_low       <= RstPeriodLow;
      cfg_q.period_high      <= RstPeriodHigh;
      cfg_q.window_ticks     <= RstWindowTicks;
      cfg_q.min_captures     <= RstMinCaptures;
      cfg_q.min_good_periods <= RstMinGoodPeriods;
      cfg_q.status_ticks     <= RstStatusTicks;
      cfg_q.blink_good_ticks <= RstBlinkGoodTicks;
      cfg_q.blink_bad_ticks  <= RstBlinkBadTicks;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD_LOW:       cfg_q.period_low       <= cfg_data_i;
        CFG_PERIOD_HIGH:      cfg_q.period_high      <= cfg_data_i;
        CFG_WINDOW_TICKS:     cfg_q.window_ticks     <= cfg_data_i;
        CFG_MIN_CAPTURES:     cfg_q.min_captures     <= cfg_data_i;
        CFG_MIN_GOOD_PERIODS: cfg_q.min_good_periods <= cfg_data_i;
        CFG_STATUS_TICKS:     cfg_q.status_ticks     <= cfg_data_i;
        CFG_BLINK_GOOD_TICKS: cfg_q.blink_good_ticks <= cfg_data_i;
        CFG_BLINK_BAD_TICKS:  cfg_q.blink_bad_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_ready_i) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

endmodule

[rtl/cpwm_checker.sv]
// ----------------------------------------------------------------------------
// Capture period window monitor checker
// Port-level assertions on the word flow, bound to the top level.
// ----------------------------------------------------------------------------
module cpwm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cpwm_pkg::out_word_t out_word_o
);

  // The input side only stalls when a finished word is waiting.
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output word pending");

  // A word accepted while the output is empty shows up at the output in the next cycle.
  a_accept_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |=> out_valid_o)
    else $error("accepted word did not reach the output");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_word_o))
    else $error("output word changed while stalled");

endmodule

bind capture_period_window_monitor cpwm_checker u_cpwm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_o (out_word_o)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the capture period window monitor
// Drives capture and tick words through the valid/ready input, predicts the
// judgement, status and LED levels of every word in a model of its own, and
// compares each output word with the oldest prediction. Register settings
// change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import cpwm_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 300;

  logic                clk;
  logic                rst_ni     = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_word_t            in_word_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  capture_period_window_monitor u_top (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Model state of the monitor.
  logic [15:0] mon_regs [8];
  logic        mon_have_prev;
  logic [15:0] mon_prev_stamp;
  logic [15:0] mon_cap_total;
  logic [15:0] mon_good_total;
  logic [15:0] mon_window_cnt;
  logic [15:0] mon_status_cnt;
  logic [15:0] mon_led_cnt;
  logic        mon_status_phase;
  logic        mon_good_flag;
  logic        mon_status_level;
  logic        mon_led_level;

  out_word_t   expected_words [$];
  out_word_t   exp_w;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_seq      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;
  int unsigned n_sent        = 0;
  int unsigned n_checked     = 0;
  int unsigned n_settings    = 0;
  int unsigned n_errors      = 0;
  logic [15:0] stim_stamp    = 16'd0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void reset_monitor_model();
    mon_regs[CFG_PERIOD_LOW]       = 16'd150;
    mon_regs[CFG_PERIOD_HIGH]      = 16'd250;
    mon_regs[CFG_WINDOW_TICKS]     = 16'd100;
    mon_regs[CFG_MIN_CAPTURES]     = 16'd3;
    mon_regs[CFG_MIN_GOOD_PERIODS] = 16'd2;
    mon_regs[CFG_STATUS_TICKS]     = 16'd10;
    mon_regs[CFG_BLINK_GOOD_TICKS] = 16'd500;
    mon_regs[CFG_BLINK_BAD_TICKS]  = 16'd250;
    mon_have_prev    = 1'b0;
    mon_prev_stamp   = 16'd0;
    mon_cap_total    = 16'd0;
    mon_good_total   = 16'd0;
    mon_window_cnt   = 16'd0;
    mon_status_cnt   = 16'd0;
    mon_led_cnt      = 16'd0;
    mon_status_phase = 1'b0;
    mon_good_flag    = 1'b0;
    mon_status_level = 1'b0;
    mon_led_level    = 1'b1;
  endfunction

  function automatic out_word_t predict_monitor_word(input in_word_t w);
    logic [15:0] diff;
    logic [15:0] led_limit;
    out_word_t   o;
    if (w.capture_valid) begin
      if (mon_have_prev) begin
        diff = w.capture_value - mon_prev_stamp;
        if (diff >= mon_regs[CFG_PERIOD_LOW] && diff <= mon_regs[CFG_PERIOD_HIGH]) begin
          mon_good_total = bump(mon_good_total);
        end
      end else begin
        mon_have_prev = 1'b1;
      end
      mon_prev_stamp = w.capture_value;
      mon_cap_total  = bump(mon_cap_total);
    end
    if (w.tick) begin
      mon_status_cnt = bump(mon_status_cnt);
      mon_window_cnt = bump(mon_window_cnt);
      mon_led_cnt    = bump(mon_led_cnt);
      if (mon_window_cnt >= mon_regs[CFG_WINDOW_TICKS]) begin
        mon_good_flag  = (mon_cap_total >= mon_regs[CFG_MIN_CAPTURES]) &&
                         (mon_good_total >= mon_regs[CFG_MIN_GOOD_PERIODS]);
        mon_cap_total  = 16'd0;
        mon_good_total = 16'd0;
        mon_window_cnt = 16'd0;
      end
      if (mon_status_cnt >= mon_regs[CFG_STATUS_TICKS]) begin
        mon_status_cnt   = 16'd0;
        mon_status_phase = ~mon_status_phase;
        mon_status_level = mon_good_flag && mon_status_phase;
      end
      led_limit = mon_good_flag ? mon_regs[CFG_BLINK_GOOD_TICKS] : mon_regs[CFG_BLINK_BAD_TICKS];
      if (mon_led_cnt >= led_limit) begin
        mon_led_cnt   = 16'd0;
        mon_led_level = ~mon_led_level;
      end
    end
    o.signal_good = mon_good_flag;
    o.status_pin  = mon_status_level;
    o.led_pin     = mon_led_level;
    return o;
  endfunction

  function automatic in_word_t make_word(input bit cap, input logic [15:0] stamp, input bit tk);
    in_word_t w;
    w.capture_valid = cap;
    w.capture_value = stamp;
    w.tick          = tk;
    return w;
  endfunction

  task automatic report_field(input string name, input logic e, input logic a);
    if (a !== e) begin
      $display("%0t: mismatch in %s, expected %0b, actual %0b", $time, name, e, a);
      n_errors++;
    end
  endtask

  // Prediction on every accepted input word, checking on every output word.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_words.push_back(predict_monitor_word(in_word_i));
        n_sent++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: output word %b with no expected word waiting", $time, out_word_o);
          n_errors++;
        end else begin
          exp_w = expected_words.pop_front();
          report_field("signal_good", exp_w.signal_good, out_word_o.signal_good);
          report_field("status_pin", exp_w.status_pin, out_word_o.status_pin);
          report_field("led_pin", exp_w.led_pin, out_word_o.led_pin);
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles, %0d words still expected",
                 $time, stall_cycles, expected_words.size());
        $display("FAIL capture_period_window_monitor");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  task automatic drain_idle();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] win, input logic [15:0] mcap,
                            input logic [15:0] mgood, input logic [15:0] st,
                            input logic [15:0] bgood, input logic [15:0] bbad);
    logic [15:0] vals [8];
    vals = '{lo, hi, win, mcap, mgood, st, bgood, bbad};
    drain_idle();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      mon_regs[i] = vals[i];
      @(posedge clk);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic test_defaults();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(make_word(1'b1, 16'd1000, 1'b0));
    send_word(make_word(1'b1, 16'd1150, 1'b0));
    send_word(make_word(1'b1, 16'd1400, 1'b1));
    send_word(make_word(1'b1, 16'd1401, 1'b1));
    send_word(make_word(1'b0, 16'hFFFF, 1'b1));
  endtask

  task automatic test_wide_window();
    set_config(16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd2);
    send_word(make_word(1'b0, 16'd0, 1'b1));
    send_word(make_word(1'b1, 16'd0, 1'b1));
    send_word(make_word(1'b1, 16'hFFFF, 1'b1));
    send_word(make_word(1'b1, 16'hFFFF, 1'b0));
    send_word(make_word(1'b0, 16'h5A5A, 1'b1));
  endtask

  task automatic test_empty_window();
    set_config(16'd300, 16'd200, 16'd2, 16'd1, 16'd1, 16'd2, 16'd3, 16'd1);
    send_word(make_word(1'b1, 16'd100, 1'b0));
    send_word(make_word(1'b1, 16'd350, 1'b1));
    send_word(make_word(1'b1, 16'd650, 1'b1));
    send_word(make_word(1'b0, 16'd0, 1'b1));
  endtask

  task automatic test_zero_limits();
    set_config(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_word(make_word(1'b0, 16'd0, 1'b1));
    send_word(make_word(1'b1, 16'd7, 1'b1));
    send_word(make_word(1'b1, 16'd7, 1'b1));
    send_word(make_word(1'b0, 16'd0, 1'b0));
  endtask

  task automatic test_wrap();
    set_config(16'd10, 16'd20, 16'd3, 16'd3, 16'd2, 16'd1, 16'd4, 16'd2);
    send_word(make_word(1'b1, 16'd65530, 1'b0));
    send_word(make_word(1'b1, 16'd4, 1'b1));
    send_word(make_word(1'b1, 16'd24, 1'b1));
    send_word(make_word(1'b1, 16'd30, 1'b1));
    send_word(make_word(1'b0, 16'd0, 1'b1));
  endtask

  task automatic randomize_config();
    int lo;
    int hi;
    case ($urandom_range(9))
      0: set_config(16'd0, 16'hFFFF, 16'($urandom_range(1, 4)), 16'd0, 16'd0,
                    16'd1, 16'd1, 16'hFFFF);
      1: begin
        lo = $urandom_range(100, 400);
        set_config(16'(lo), 16'(lo - $urandom_range(1, 50)), 16'($urandom_range(1, 6)),
                   16'($urandom_range(0, 3)), 16'($urandom_range(0, 2)),
                   16'($urandom_range(1, 5)), 16'($urandom_range(1, 6)),
                   16'($urandom_range(1, 6)));
      end
      2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF);
      default: begin
        lo = $urandom_range(0, 300);
        hi = lo + $urandom_range(0, 200);
        set_config(16'(lo), 16'(hi), 16'($urandom_range(1, 12)),
                   16'($urandom_range(0, 5)), 16'($urandom_range(0, 4)),
                   16'($urandom_range(1, 6)), 16'($urandom_range(1, 9)),
                   16'($urandom_range(1, 9)));
      end
    endcase
  endtask

  task automatic test_random(input int n_words, input int s_pct, input int r_pct);
    int       lo;
    int       hi;
    int       d;
    in_word_t w;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_words; i++) begin
      if (i % 100 == 0) randomize_config();
      w.capture_valid = ($urandom_range(99) < 55);
      w.tick          = ($urandom_range(99) < 45);
      w.capture_value = 16'($urandom);
      if (w.capture_valid && $urandom_range(99) < 70) begin
        lo = mon_regs[CFG_PERIOD_LOW];
        hi = mon_regs[CFG_PERIOD_HIGH];
        if (hi >= lo && hi - lo < 4000) begin
          d = lo - 3 + $urandom_range(0, hi - lo + 6);
        end else begin
          d = $urandom_range(0, 500);
        end
        w.capture_value = stim_stamp + 16'(d);
      end
      if (w.capture_valid) stim_stamp = w.capture_value;
      send_word(w);
    end
  endtask

  task automatic test_backpressure();
    set_config(16'd5, 16'd40, 16'd4, 16'd2, 16'd1, 16'd2, 16'd3, 16'd5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq++;
    for (int i = 0; i < 40; i++) begin
      stim_stamp = stim_stamp + 16'($urandom_range(0, 45));
      send_word(make_word(1'($urandom), stim_stamp, 1'($urandom)));
    end
  endtask

  initial begin
    reset_monitor_model();
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_wide_window();
    test_empty_window();
    test_zero_limits();
    test_wrap();
    test_backpressure();
    test_random(345, 25, 68);
    test_random(345, 68, 25);
    test_random(345, 0, 0);
    drain_idle();
    repeat (20) @(posedge clk);
    $display("Summary: %0d words sent, %0d output words checked, %0d register settings.",
             n_sent, n_checked, n_settings);
    $display("Covered idle and stall mixes, a long output hold-off and timestamp wrap.");
    if (n_errors == 0) begin
      $display("PASS capture_period_window_monitor");
    end else begin
      $display("FAIL capture_period_window_monitor");
    end
    $finish;
  end

endmodule
